@@ hdl/skss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skss_pkg
// Shared types and constants for the sorted keyed stack store: request and
// response payloads, response kind codes and default sizes.
// ----------------------------------------------------------------------------
package skss_pkg;

  localparam int KEY_W   = 16;
  localparam int COLOR_W = 8;

  localparam int MAX_COLUMNS_DEF  = 16;
  localparam int POOL_ENTRIES_DEF = 64;

  // Command carried by a request.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // Kind of a response.
  typedef enum logic [1:0] {
    KIND_PUSH_OK   = 2'd0,
    KIND_PUSH_FULL = 2'd1,
    KIND_ENTRY     = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [KEY_W-1:0]   column;
    logic [COLOR_W-1:0] color;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   out_column;
    logic [COLOR_W-1:0] out_color;
    logic               first_in_column;
    logic               last_of_dump;
  } rsp_t;

endpackage
`default_nettype wire

@@ hdl/skss_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skss_ifs
// Valid/ready channels for requests into and responses out of the store.
// ----------------------------------------------------------------------------
interface skss_req_if;
  import skss_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface skss_rsp_if;
  import skss_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/sorted_keyed_stack_store_top.sv @@
`default_nettype none
// A request's keys are compared and its pool memory read at the accepting
// edge; its response is formed in the push or read state and loaded into the
// output register once that register is free of a stalled receiver. The
// input is held off while a request is in flight, so a new request is taken
// only once the last response is loaded. Reset clears the column and pool
// counts and the dump cursor at once; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_keyed_stack_store_top
// Keeps one stack of colours per column key, keys sorted in ascending order
// in a row of compare cells, entries in a linked pool memory. Read requests
// walk the store column by column, newest entry first, and clear it at end.
// ----------------------------------------------------------------------------
module sorted_keyed_stack_store_top #(
  parameter int MAX_COLUMNS  = skss_pkg::MAX_COLUMNS_DEF,
  parameter int POOL_ENTRIES = skss_pkg::POOL_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  skss_req_if.sink    req,
  skss_rsp_if.source  rsp
);
  import skss_pkg::*;

  localparam int SIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int PIW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int PCW = $clog2(POOL_ENTRIES + 1);
  localparam int MW  = 1 + PIW + COLOR_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PUSH = 3'b010,
    ST_READ = 3'b100
  } state_t;

  typedef struct packed {
    logic               last;
    logic [PIW-1:0]     link;
    logic [COLOR_W-1:0] color;
  } pool_word_t;

  state_t state;

  // Column cells and counters.
  logic [KEY_W-1:0] keys  [MAX_COLUMNS];
  logic [PIW-1:0]   heads [MAX_COLUMNS];
  logic [CCW-1:0]   columns_used;
  logic [PCW-1:0]   pool_used;
  logic [SIW-1:0]   read_slot;
  logic [PIW-1:0]   read_entry;
  logic             read_started;

  // Pool memory.
  pool_word_t       pool_mem [POOL_ENTRIES];
  pool_word_t       pool_rd;
  logic             mem_we;
  logic             mem_re;
  logic [PIW-1:0]   mem_waddr;
  logic [PIW-1:0]   mem_raddr;
  pool_word_t       mem_wdata;

  // Request registers.
  logic [KEY_W-1:0]       key_q;
  logic [COLOR_W-1:0]     color_q;
  logic [MAX_COLUMNS-1:0] lt_q;
  logic                   found_q;
  logic [SIW-1:0]         slot_q;
  logic                   first_q;
  logic                   empty_q;

  rsp_t out_q;
  logic out_valid;

  logic             accept;
  logic             commit;
  logic [MAX_COLUMNS-1:0] lt_vec;
  logic [MAX_COLUMNS-1:0] eq_vec;
  logic [SIW-1:0]   pos;
  logic             refuse;
  logic             push_do;
  logic             wrap;
  logic [SIW-1:0]   slot_sel;
  logic [SIW-1:0]   hd_addr;
  logic [PIW-1:0]   heads_rd;
  logic [CCW:0]     slot_inc;
  logic             dump_last;
  rsp_t             rsp_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign commit    = (state != ST_IDLE) && (!out_valid || rsp.ready);

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;

  // Parallel compare of the incoming key against every occupied cell.
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      lt_vec[i] = (CCW'(i) < columns_used) && (keys[i] < req.payload.column);
      eq_vec[i] = (CCW'(i) < columns_used) && (keys[i] == req.payload.column);
    end
  end

  // Insert position: the keys below the new one form a run from slot zero.
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      if (lt_q[i]) begin
        pos = SIW'(i + 1);
      end
    end
  end

  assign refuse  = (pool_used == PCW'(POOL_ENTRIES)) ||
                   (!found_q && (columns_used == CCW'(MAX_COLUMNS)));
  assign push_do = commit && (state == ST_PUSH) && !refuse;

  // Dump cursor as seen by a new read request.
  assign wrap     = ({1'b0, read_slot} >= (SIW + 1)'(columns_used));
  assign slot_sel = wrap ? '0 : read_slot;
  assign hd_addr  = (state == ST_PUSH) ? pos : slot_sel;
  assign heads_rd = heads[hd_addr];

  // Pool memory accesses.
  assign mem_re    = accept && (req.payload.cmd == CMD_READ);
  assign mem_raddr = (read_started && !wrap) ? read_entry : heads_rd;
  assign mem_we    = push_do;
  assign mem_waddr = pool_used[PIW-1:0];
  always_comb begin
    mem_wdata.last  = !found_q;
    mem_wdata.link  = heads_rd;
    mem_wdata.color = color_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      pool_rd <= pool_mem[mem_raddr];
    end
  end

  // Response formation.
  assign slot_inc  = {1'b0, CCW'(slot_q)} + (CCW + 1)'(1);
  assign dump_last = pool_rd.last && (slot_inc >= {1'b0, columns_used});

  always_comb begin
    rsp_next = '0;
    if (state == ST_PUSH) begin
      rsp_next.kind = refuse ? KIND_PUSH_FULL : KIND_PUSH_OK;
    end else if (empty_q) begin
      rsp_next.kind = KIND_EMPTY;
    end else begin
      rsp_next.kind            = KIND_ENTRY;
      rsp_next.out_column      = keys[slot_q];
      rsp_next.out_color       = pool_rd.color;
      rsp_next.first_in_column = first_q;
      rsp_next.last_of_dump    = dump_last;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_q   <= req.payload.column;
      color_q <= req.payload.color;
      lt_q    <= lt_vec;
      found_q <= |eq_vec;
      slot_q  <= slot_sel;
      first_q <= !(read_started && !wrap);
      empty_q <= (columns_used == '0);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (req.payload.cmd == CMD_PUSH) ? ST_PUSH : ST_READ;
          end
        end
        ST_PUSH, ST_READ: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_q <= rsp_next;
    end
  end

  // Counters and dump cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_used <= '0;
      pool_used    <= '0;
      read_slot    <= '0;
      read_entry   <= '0;
      read_started <= 1'b0;
    end else if (push_do) begin
      if (!found_q) begin
        columns_used <= columns_used + CCW'(1);
      end
      pool_used    <= pool_used + PCW'(1);
      read_slot    <= '0;
      read_entry   <= '0;
      read_started <= 1'b0;
    end else if (commit && (state == ST_READ) && !empty_q) begin
      if (pool_rd.last) begin
        read_started <= 1'b0;
        read_entry   <= '0;
        if (dump_last) begin
          columns_used <= '0;
          pool_used    <= '0;
          read_slot    <= '0;
        end else begin
          read_slot <= SIW'(slot_inc);
        end
      end else begin
        read_slot    <= slot_q;
        read_entry   <= pool_rd.link;
        read_started <= 1'b1;
      end
    end
  end

  // Column cells: shift up above the insert point, or renew the head.
  for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (push_do) begin
        if (SIW'(g) == pos) begin
          keys[g]  <= key_q;
          heads[g] <= pool_used[PIW-1:0];
        end else if (!found_q && (SIW'(g) > pos)) begin
          if (g > 0) begin
            keys[g]  <= keys[(g > 0) ? g - 1 : 0];
            heads[g] <= heads[(g > 0) ? g - 1 : 0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/skss_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skss_tb_pkg
// Scoreboard for the sorted keyed stack store. It keeps its own copy of the
// column keys, the stack heads, the entry pool and the dump cursor. From that
// copy it predicts the response to every accepted request and checks the
// responses in order.
// ----------------------------------------------------------------------------
package skss_tb_pkg;
  import skss_pkg::*;

  localparam int COLUMN_SLOTS = MAX_COLUMNS_DEF;
  localparam int POOL_SIZE    = POOL_ENTRIES_DEF;
  localparam int END_OF_STACK = POOL_SIZE;

  class stack_store_scoreboard;
    logic [KEY_W-1:0]   slot_key [COLUMN_SLOTS];
    int                 slot_top [COLUMN_SLOTS];
    logic [COLOR_W-1:0] entry_color [POOL_SIZE];
    int                 entry_below [POOL_SIZE];
    int                 slots_held;
    int                 entries_held;
    int                 dump_slot;
    int                 dump_entry;
    bit                 dump_started;
    rsp_t               expected_rsp [$];
    int                 fail_count;

    function new();
      slots_held   = 0;
      entries_held = 0;
      fail_count   = 0;
      rewind_dump();
    endfunction

    function void rewind_dump();
      dump_slot    = 0;
      dump_entry   = 0;
      dump_started = 1'b0;
    endfunction

    function int pending_count();
      return expected_rsp.size();
    endfunction

    // Places a colour on the stack of its column, opening the column at its
    // sorted place when the key is new.
    function kind_t push_color(logic [KEY_W-1:0] key, logic [COLOR_W-1:0] color);
      int  pos;
      bit  found;
      pos   = slots_held;
      found = 1'b0;
      for (int i = 0; i < slots_held; i++) begin
        if (slot_key[i] == key) begin
          found = 1'b1;
          pos   = i;
          break;
        end
        if (slot_key[i] > key) begin
          pos = i;
          break;
        end
      end
      if (entries_held >= POOL_SIZE) return KIND_PUSH_FULL;
      if (!found && slots_held >= COLUMN_SLOTS) return KIND_PUSH_FULL;

      entry_color[entries_held] = color;
      if (found) begin
        entry_below[entries_held] = slot_top[pos];
      end else begin
        entry_below[entries_held] = END_OF_STACK;
        for (int i = slots_held; i > pos; i--) begin
          slot_key[i] = slot_key[i-1];
          slot_top[i] = slot_top[i-1];
        end
        slot_key[pos] = key;
        slots_held++;
      end
      slot_top[pos] = entries_held;
      entries_held++;
      rewind_dump();
      return KIND_PUSH_OK;
    endfunction

    // Works out the next entry of the dump and moves the cursor on; the store
    // empties itself after its final entry.
    function rsp_t next_dump_entry();
      rsp_t rsp;
      int   entry;
      int   below;
      rsp = '0;
      if (slots_held == 0) begin
        rsp.kind = KIND_EMPTY;
        return rsp;
      end
      if (dump_slot >= slots_held) rewind_dump();
      if (dump_started) begin
        entry = dump_entry;
      end else begin
        entry = slot_top[dump_slot];
        rsp.first_in_column = 1'b1;
      end
      rsp.kind       = KIND_ENTRY;
      rsp.out_column = slot_key[dump_slot];
      rsp.out_color  = entry_color[entry];
      below          = entry_below[entry];
      if (below == END_OF_STACK) begin
        if (dump_slot + 1 >= slots_held) begin
          rsp.last_of_dump = 1'b1;
          slots_held       = 0;
          entries_held     = 0;
          rewind_dump();
        end else begin
          dump_slot    = dump_slot + 1;
          dump_started = 1'b0;
          dump_entry   = 0;
        end
      end else begin
        dump_entry   = below;
        dump_started = 1'b1;
      end
      return rsp;
    endfunction

    // Called for every request the store accepts.
    function void note_request(req_t req);
      rsp_t rsp;
      if (req.cmd == CMD_PUSH) begin
        rsp      = '0;
        rsp.kind = push_color(req.column, req.color);
      end else begin
        rsp = next_dump_entry();
      end
      expected_rsp.push_back(rsp);
    endfunction

    function void report_field(string field, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s expected %0h, actual %0h", $time, field, exp_val, act_val);
        fail_count++;
      end
    endfunction

    // Called for every response the store hands over.
    function void check_response(rsp_t act);
      rsp_t exp;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none expected, actual %0h", $time, act);
        fail_count++;
        return;
      end
      exp = expected_rsp.pop_front();
      report_field("kind", exp.kind, act.kind);
      report_field("out_column", exp.out_column, act.out_column);
      report_field("out_color", exp.out_color, act.out_color);
      report_field("first_in_column", exp.first_in_column, act.first_in_column);
      report_field("last_of_dump", exp.last_of_dump, act.last_of_dump);
    endfunction
  endclass

endpackage

@@ tb/sv/tb_sorted_keyed_stack_store_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_keyed_stack_store_top
// Drives push and read requests into the sorted keyed stack store and checks
// every response against the scoreboard's prediction. A directed opening
// covers key and colour extremes, pushes onto existing columns, inserts in
// the middle and a push during a dump; random sequences then fill columns
// and the pool past capacity and dump the store, mixed with noise. Both
// channels idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_sorted_keyed_stack_store_top;
  import skss_pkg::*;
  import skss_tb_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 120;

  logic clk = 1'b0;
  logic rst;

  skss_req_if req_ch ();
  skss_rsp_if rsp_ch ();

  sorted_keyed_stack_store_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  stack_store_scoreboard store_sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int sent_items    = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one has been asked for.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every response handed over is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) store_sb.check_response(rsp_ch.payload);
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one request, after an optional gap, and notes it once accepted.
  // Valid stays high on return so that back-to-back requests need no toggle.
  task automatic send_request(input cmd_t cmd, input logic [KEY_W-1:0] column,
                              input logic [COLOR_W-1:0] color);
    req_t item;
    item.cmd    = cmd;
    item.column = column;
    item.color  = color;
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.payload <= item;
    req_ch.valid   <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    store_sb.note_request(item);
    sent_items++;
  endtask

  // Reads until the store has given its final entry and cleared itself.
  task automatic dump_store();
    while (store_sb.entries_held != 0)
      send_request(CMD_READ, KEY_W'($urandom), COLOR_W'($urandom));
  endtask

  initial begin
    int               seq_no;
    int               pick;
    int               base_items;
    int               progress;
    int               key_count;
    bit               pressed;
    logic [KEY_W-1:0] key_set [8];

    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    send_idle_pct = 11;
    recv_idle_pct = 82;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty read, extremes, existing column, middle insert.
    send_request(CMD_READ, 16'hFFFF, 8'hFF);
    send_request(CMD_PUSH, 16'hFFFF, 8'hFF);
    send_request(CMD_PUSH, 16'h0000, 8'h00);
    send_request(CMD_PUSH, 16'h0000, 8'hAA);
    send_request(CMD_PUSH, 16'h8000, 8'h5A);
    send_request(CMD_PUSH, 16'h0001, 8'hA5);
    send_request(CMD_PUSH, 16'hFFFF, 8'h01);
    // A partial dump, then a push that sends the cursor back to the start.
    send_request(CMD_READ, 16'h0000, 8'h00);
    send_request(CMD_READ, 16'h5555, 8'h55);
    send_request(CMD_PUSH, 16'h7FFF, 8'h80);
    dump_store();
    send_request(CMD_READ, 16'hAAAA, 8'hAA);

    // Random sequences, mostly well formed.
    base_items = sent_items;
    seq_no     = 0;
    pressed    = 1'b0;
    while (sent_items - base_items < RANDOM_ITEMS) begin
      progress = sent_items - base_items;
      if (progress < RANDOM_ITEMS / 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 82;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!pressed) begin
          pressed = 1'b1;
          holds_asked++;
        end
      end

      key_count = $urandom_range(1, 8);
      foreach (key_set[i]) begin
        case ($urandom_range(7))
          0:       key_set[i] = '0;
          1:       key_set[i] = '1;
          default: key_set[i] = KEY_W'($urandom);
        endcase
      end

      pick = (seq_no < 2) ? seq_no : $urandom_range(2, 9);
      seq_no++;
      case (pick)
        // More distinct columns than there are slots.
        0: begin
          repeat (COLUMN_SLOTS + 4)
            send_request(CMD_PUSH, KEY_W'($urandom), COLOR_W'($urandom));
          dump_store();
        end
        // More entries than the pool holds, on a few columns.
        1: begin
          repeat (POOL_SIZE + 4)
            send_request(CMD_PUSH, key_set[$urandom_range(2)], COLOR_W'($urandom));
          dump_store();
        end
        // Fill from a small key set, then dump it all.
        2, 3, 4: begin
          repeat ($urandom_range(1, 24))
            send_request(CMD_PUSH, key_set[$urandom_range(key_count - 1)],
                         COLOR_W'($urandom));
          dump_store();
        end
        // Dump cut short by a push, then dumped again from the start.
        5, 6: begin
          repeat ($urandom_range(2, 16))
            send_request(CMD_PUSH, key_set[$urandom_range(key_count - 1)],
                         COLOR_W'($urandom));
          repeat ($urandom_range(1, store_sb.entries_held - 1))
            send_request(CMD_READ, KEY_W'($urandom), COLOR_W'($urandom));
          send_request(CMD_PUSH, key_set[$urandom_range(key_count - 1)],
                       COLOR_W'($urandom));
          dump_store();
        end
        // Noise: any command with any fields.
        7: begin
          repeat ($urandom_range(4, 12))
            send_request(cmd_t'($urandom_range(1)), KEY_W'($urandom), COLOR_W'($urandom));
        end
        // Many columns with fully random keys.
        8: begin
          repeat ($urandom_range(10, 24))
            send_request(CMD_PUSH, KEY_W'($urandom), COLOR_W'($urandom));
          dump_store();
        end
        // Reads past the end of a dump.
        default: begin
          dump_store();
          repeat ($urandom_range(1, 3))
            send_request(CMD_READ, KEY_W'($urandom), COLOR_W'($urandom));
        end
      endcase
    end
    req_ch.valid <= 1'b0;

    // Let the last responses through, then allow for anything stray.
    while (store_sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (store_sb.fail_count == 0 && store_sb.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/skss_pkg.sv
hdl/skss_ifs.sv
hdl/sorted_keyed_stack_store_top.sv
tb/sv/skss_tb_pkg.sv
tb/sv/tb_sorted_keyed_stack_store_top.sv
